// File: rtl/text_console_cursor_scroll_top_defines.svh
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define TCCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define TCCS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg: text console shared definitions
// Field widths, operation codes and the controller/datapath command and
// status structures.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// Screen geometry defaults
	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF    = 25;

	// Field widths
	localparam int unsigned OPCODE_W  = 3;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned TCOL_W    = 7;
	localparam int unsigned TROW_W    = 5;
	localparam int unsigned CIDX_W    = 11;
	localparam int unsigned CURPOS_W  = 11;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CELL_W    = 16;
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 24;

	// Attribute word stored with every written character
	localparam logic [CELL_W-1:0] ATTR_WORD = 16'h0F00;

	// Console modes
	localparam logic [MODE_W-1:0] MODE_FREE       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SHELL      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHELL_PROG = 2'd2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PRINT      = 3'd0,
		OP_NEWLINE    = 3'd1,
		OP_BACKSPACE  = 3'd2,
		OP_CLEAR      = 3'd3,
		OP_SET_CURSOR = 3'd4,
		OP_READ_CELL  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_INC_COL,
		CUR_DEC_COL,
		CUR_NEWLINE,
		CUR_PREV_ROW,
		CUR_SET,
		CUR_HOME
	} cursor_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_CLEAR,
		CNT_INC
	} cnt_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CURSOR,
		WR_FILL
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_INDEX,
		RD_SCROLL,
		RD_LEFT
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic       ld_item;
		cursor_op_t cur_op;
		cnt_op_t    cnt_op;
		wr_sel_t    wr_sel;
		logic       fill_attr;
		rd_sel_t    rd_sel;
		logic       out_load;
		logic       out_use_mem;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    col_wrap;
		logic    row_bottom;
		logic    col_above_limit;
		logic    bs_prev_row;
		logic    idx_valid;
		logic    char_zero;
		logic    cnt_copy_end;
		logic    cnt_last;
	} dp_status_t;

endpackage

// File: rtl/tccs_datapath.sv
// ----------------------------------------------------------------------------
// tccs_datapath: text console cell store and cursor
// Holds the cell memory, cursor, mode register, sweep counter and the
// latched item; executes controller commands and reports status.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_top_defines.svh"

module tccs_datapath #(
	parameter int unsigned COLUMNS = tccs_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tccs_pkg::ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tccs_pkg::MODE_W-1:0]    cfg_wr_data,
	input  logic [tccs_pkg::OPCODE_W-1:0]  in_opcode,
	input  logic [tccs_pkg::CHAR_W-1:0]    in_char,
	input  logic [tccs_pkg::TCOL_W-1:0]    in_tcol,
	input  logic [tccs_pkg::TROW_W-1:0]    in_trow,
	input  logic [tccs_pkg::CIDX_W-1:0]    in_cidx,
	input  tccs_pkg::dp_cmd_t              cmd,
	output tccs_pkg::dp_status_t           status,
	output logic [tccs_pkg::CURPOS_W-1:0]  res_pos,
	output logic [tccs_pkg::CHAR_W-1:0]    res_char
);
	import tccs_pkg::*;

	localparam int unsigned CELLS  = COLUMNS * ROWS;
	localparam int unsigned COL_W  = $clog2(COLUMNS + 1);
	localparam int unsigned ROW_W  = $clog2(ROWS);
	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned POS_W  = $clog2(CELLS + 1);

	logic [MODE_W-1:0] mode_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] waddr_s1;
	opcode_t           op_q;
	logic [CHAR_W-1:0] wchar_q;
	logic [TCOL_W-1:0] tcol_q;
	logic [TROW_W-1:0] trow_q;
	logic [CIDX_W-1:0] cidx_q;
	logic [CELL_W-1:0] rdata_q;
	logic [CELL_W-1:0] mem [CELLS];

	logic [POS_W-1:0]  pos;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] left_addr;
	logic [ADDR_W-1:0] scroll_src;
	logic              shell_mode;
	logic              idx_valid;
	logic              col_wrap;
	logic              row_bottom;
	logic [COL_W-1:0]  tcol_clamp;
	logic [ROW_W-1:0]  trow_clamp;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	// Cursor address and derived conditions
	always_comb begin
		pos        = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
		cur_addr   = ADDR_W'(pos);
		left_addr  = ADDR_W'(pos - POS_W'(1));
		scroll_src = cnt_q + ADDR_W'(COLUMNS);
		shell_mode = (mode_q == MODE_SHELL) || (mode_q == MODE_SHELL_PROG);
		idx_valid  = 32'(cidx_q) < 32'(CELLS);
		col_wrap   = col_q > COL_W'(COLUMNS - 1);
		row_bottom = 32'(row_q) >= 32'(ROWS - 1);
		tcol_clamp = (32'(tcol_q) > 32'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(tcol_q);
		trow_clamp = (32'(trow_q) > 32'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(trow_q);
	end

	// Status back to the controller
	always_comb begin
		status.op              = op_q;
		status.col_wrap        = col_wrap;
		status.row_bottom      = row_bottom;
		status.col_above_limit = shell_mode ? (col_q > COL_W'(2)) : (col_q != '0);
		status.bs_prev_row     = (row_q != '0) && (mode_q == MODE_FREE);
		status.idx_valid       = idx_valid;
		status.char_zero       = rdata_q[CHAR_W-1:0] == '0;
		status.cnt_copy_end    = cnt_q == ADDR_W'(CELLS - COLUMNS);
		status.cnt_last        = cnt_q == ADDR_W'(CELLS - 1);
	end

	// Result fields
	assign res_pos  = CURPOS_W'(pos);
	assign res_char = cmd.out_use_mem ? rdata_q[CHAR_W-1:0] : '0;

	// Memory port selection; the scroll copy write owns the port when pending
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {ATTR_WORD[CELL_W-1:CHAR_W], wchar_q};
		if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = rdata_q;
		end else begin
			case (cmd.wr_sel)
				WR_CURSOR: begin
					mem_we = 1'b1;
				end
				WR_FILL: begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q;
					mem_wdata = cmd.fill_attr ? ATTR_WORD : '0;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		mem_re    = cmd.rd_sel != RD_NONE;
		case (cmd.rd_sel)
			RD_INDEX:  mem_raddr = ADDR_W'(cidx_q);
			RD_SCROLL: mem_raddr = scroll_src;
			RD_LEFT:   mem_raddr = left_addr;
			default:   mem_raddr = cur_addr;
		endcase
	end

	// Cell store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			op_q    <= opcode_t'(in_opcode);
			wchar_q <= (opcode_t'(in_opcode) == OP_PRINT) ? in_char : '0;
			tcol_q  <= in_tcol;
			trow_q  <= in_trow;
			cidx_q  <= in_cidx;
		end
		waddr_s1 <= cnt_q;
	end

	// Mode register, cursor, sweep counter and scroll write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FREE;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			case (cmd.cur_op)
				CUR_INC_COL: col_q <= col_q + COL_W'(1);
				CUR_DEC_COL: col_q <= col_q - COL_W'(1);
				CUR_NEWLINE: begin
					col_q <= '0;
					if (!row_bottom) begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				CUR_PREV_ROW: begin
					row_q <= row_q - ROW_W'(1);
					col_q <= COL_W'(COLUMNS - 1);
				end
				CUR_SET: begin
					col_q <= tcol_clamp;
					row_q <= trow_clamp;
				end
				CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
					col_q <= col_q;
				end
			endcase
			case (cmd.cnt_op)
				CNT_CLEAR: cnt_q <= '0;
				CNT_INC:   cnt_q <= cnt_q + ADDR_W'(1);
				default:   cnt_q <= cnt_q;
			endcase
			pend_s1 <= cmd.rd_sel == RD_SCROLL;
		end
	end

	`TCCS_ASSERT_NEVER(a_wr_port_clash, pend_s1 && (cmd.wr_sel != WR_NONE), "write port clash with scroll copy")
	`TCCS_ASSERT(a_cursor_range, (32'(col_q) <= 32'(COLUMNS)) && (32'(row_q) <= 32'(ROWS - 1)), "cursor out of range")
	`TCCS_ASSERT(a_put_in_row, (cmd.wr_sel == WR_CURSOR) |-> !col_wrap, "cell write past last column")

endmodule

// File: rtl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl: text console sequencer
// State machine that accepts items, sequences memory sweeps, the backspace
// back-scan and scroll copy, and hands results to the output register.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_top_defines.svh"

module tccs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  out_busy,
	input  tccs_pkg::dp_status_t  status,
	output tccs_pkg::dp_cmd_t     cmd
);
	import tccs_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_BLANK,
		ST_PUT,
		ST_BS_RD,
		ST_BS_CHK,
		ST_CLEAR,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rd_hit_q;

	assign s_tready = (state_q == ST_IDLE) || ((state_q == ST_RESP) && !out_busy);

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		cmd.ld_item     = 1'b0;
		cmd.cur_op      = CUR_HOLD;
		cmd.cnt_op      = CNT_HOLD;
		cmd.wr_sel      = WR_NONE;
		cmd.fill_attr   = 1'b1;
		cmd.rd_sel      = RD_NONE;
		cmd.out_load    = 1'b0;
		cmd.out_use_mem = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.wr_sel    = WR_FILL;
				cmd.fill_attr = 1'b0;
				cmd.cnt_op    = CNT_INC;
				if (status.cnt_last) begin
					cmd.cnt_op = CNT_CLEAR;
					state_d    = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.ld_item = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (status.op)
					OP_PRINT: begin
						if (status.col_wrap) begin
							cmd.cur_op = CUR_NEWLINE;
							if (status.row_bottom) begin
								cmd.cnt_op = CNT_CLEAR;
								state_d    = ST_SCROLL;
							end else begin
								state_d = ST_PUT;
							end
						end else begin
							cmd.wr_sel = WR_CURSOR;
							cmd.cur_op = CUR_INC_COL;
							state_d    = ST_RESP;
						end
					end
					OP_NEWLINE: begin
						cmd.cur_op = CUR_NEWLINE;
						if (status.row_bottom) begin
							cmd.cnt_op = CNT_CLEAR;
							state_d    = ST_SCROLL;
						end else begin
							state_d = ST_RESP;
						end
					end
					OP_BACKSPACE: begin
						if (status.col_above_limit) begin
							cmd.cur_op = CUR_DEC_COL;
							state_d    = ST_PUT;
						end else if (status.bs_prev_row) begin
							cmd.cur_op = CUR_PREV_ROW;
							state_d    = ST_BS_RD;
						end else begin
							state_d = ST_PUT;
						end
					end
					OP_CLEAR: begin
						cmd.cur_op = CUR_HOME;
						cmd.cnt_op = CNT_CLEAR;
						state_d    = ST_CLEAR;
					end
					OP_SET_CURSOR: begin
						cmd.cur_op = CUR_SET;
						state_d    = ST_RESP;
					end
					OP_READ_CELL: begin
						if (status.idx_valid) begin
							cmd.rd_sel = RD_INDEX;
						end
						state_d = ST_RESP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			// Copy each row up one; the write of each cell trails its read
			ST_SCROLL: begin
				if (status.cnt_copy_end) begin
					state_d = ST_BLANK;
				end else begin
					cmd.rd_sel = RD_SCROLL;
					cmd.cnt_op = CNT_INC;
				end
			end
			// Blank the bottom row
			ST_BLANK: begin
				cmd.wr_sel = WR_FILL;
				cmd.cnt_op = CNT_INC;
				if (status.cnt_last) begin
					cmd.cnt_op = CNT_CLEAR;
					state_d    = (status.op == OP_PRINT) ? ST_PUT : ST_RESP;
				end
			end
			ST_PUT: begin
				cmd.wr_sel = WR_CURSOR;
				if (status.op == OP_PRINT) begin
					cmd.cur_op = CUR_INC_COL;
				end
				state_d = ST_RESP;
			end
			// Back-scan over empty cells on the previous row
			ST_BS_RD: begin
				if (status.col_above_limit) begin
					cmd.rd_sel = RD_LEFT;
					state_d    = ST_BS_CHK;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_BS_CHK: begin
				if (status.char_zero) begin
					cmd.cur_op = CUR_DEC_COL;
					state_d    = ST_BS_RD;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_CLEAR: begin
				cmd.wr_sel = WR_FILL;
				cmd.cnt_op = CNT_INC;
				if (status.cnt_last) begin
					cmd.cnt_op = CNT_CLEAR;
					state_d    = ST_RESP;
				end
			end
			// Once the output register is free, hand off the result and take the next item in the same cycle
			ST_RESP: begin
				cmd.out_use_mem = rd_hit_q;
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					if (s_tvalid) begin
						cmd.ld_item = 1'b1;
						state_d     = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and read-hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			rd_hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				rd_hit_q <= (status.op == OP_READ_CELL) && status.idx_valid;
			end
		end
	end

	`TCCS_ASSERT(a_load_free, cmd.out_load |-> !out_busy, "result register overwritten")
	`TCCS_ASSERT(a_accept_exec, (s_tvalid && s_tready) |=> (state_q == ST_EXEC), "accepted item not executed")
	`TCCS_ASSERT(a_chk_after_rd, (state_q == ST_BS_CHK) |-> ($past(state_q) == ST_BS_RD), "back-scan check without read")

endmodule

// File: rtl/text_console_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top: character-cell text screen engine
// Print, set cursor, read cell: ST_EXEC then ST_RESP per item; a late print wrap adds ST_PUT.
// Newline on the bottom row scrolls the rows up and blanks the bottom row; clear fills all cells.
// Backspace back-scan reads each skipped cell; all fill and copy sweeps use the single write port.
// Reset: async, active low; a pass over all ROWS*COLUMNS cells zeroes them, no input taken.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top #(
	parameter int unsigned COLUMNS = tccs_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tccs_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tccs_pkg::MODE_W-1:0]     cfg_wr_data,  // console_mode
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// char_code[7:0], target_column[14:8], target_row[19:15], cell_index[30:20]
	input  logic [tccs_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [tccs_pkg::OPCODE_W-1:0]   s_tuser,      // opcode[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cursor_position[10:0], read_char[18:11]
	output logic [tccs_pkg::M_TDATA_W-1:0]  m_tdata
);
	import tccs_pkg::*;

	dp_cmd_t                cmd;
	dp_status_t             status;
	logic [CURPOS_W-1:0]    res_pos;
	logic [CHAR_W-1:0]      res_char;
	logic                   out_busy;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	assign out_busy = m_tvalid_q && !m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_busy (out_busy),
		.status   (status),
		.cmd      (cmd)
	);

	tccs_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_opcode   (s_tuser),
		.in_char     (s_tdata[7:0]),
		.in_tcol     (s_tdata[14:8]),
		.in_trow     (s_tdata[19:15]),
		.in_cidx     (s_tdata[30:20]),
		.cmd         (cmd),
		.status      (status),
		.res_pos     (res_pos),
		.res_char    (res_char)
	);

	// Output register: load a finished result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {{(M_TDATA_W - CURPOS_W - CHAR_W){1'b0}}, res_char, res_pos};
		end
	end

endmodule
